### design/jet_pkg.sv
package jet_pkg;

  localparam int FRAC_BITS_DEF = 28;

  localparam logic signed [31:0] C_REAL_RST    = 32'sd0;
  localparam logic signed [31:0] C_IMAG_RST    = 32'sd0;
  localparam logic [2:0]         RADIUS_RST    = 3'd2;
  localparam logic [15:0]        MAX_ITER_RST  = 16'd5000;

  typedef enum logic [1:0] {
    CFG_C_REAL   = 2'd0,
    CFG_C_IMAG   = 2'd1,
    CFG_RADIUS   = 2'd2,
    CFG_MAX_ITER = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;
  } in_t;

  typedef struct packed {
    logic [15:0] escape_count;
    logic [4:0]  shade_level;
  } out_t;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic [2:0]         escape_radius;
    logic [15:0]        max_iterations;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_EVAL = 2'd2
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic escaped;
    logic at_limit;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // floor(log2(count + 1))
  function automatic logic [4:0] shade_of(input logic [15:0] count);
    logic [16:0] t;
    logic [4:0]  res;
    t   = {1'b0, count} + 17'd1;
    res = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (t[i]) begin
        res = 5'(i);
      end
    end
    return res;
  endfunction

endpackage

### design/julia_escape_time.sv
// Julia-set escape-time unit. Each request (start while busy is low) carries a
// pixel's start point z; the unit iterates z = z*z + c until |z| passes the
// escape radius or the count reaches max_iterations, then shows escape_count and
// shade_level = floor(log2(1 + count)) on out_data for exactly one cycle with
// out_valid high. The receiver cannot stall, so capture the result in that cycle.
// Each update passes first through the MUL state, which registers the three
// 32x32 products, and then through EVAL, which does the modulus test and the
// saturating add of c. Busy falls in the cycle the result appears, and a new
// request may be taken then. Write configuration only while busy is low.
module julia_escape_time #(
  parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  jet_pkg::in_t   in_data,
  output logic           out_valid,
  output jet_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_addr,
  input  logic [31:0]    cfg_wdata
);
  import jet_pkg::*;

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;
  out_t    res;
  logic    out_valid_r, out_valid_nxt;
  out_t    out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real         <= C_REAL_RST;
      cfg_r.c_imag         <= C_IMAG_RST;
      cfg_r.escape_radius  <= RADIUS_RST;
      cfg_r.max_iterations <= MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_C_REAL:   cfg_r.c_real         <= cfg_wdata;
        CFG_C_IMAG:   cfg_r.c_imag         <= cfg_wdata;
        CFG_RADIUS:   cfg_r.escape_radius  <= cfg_wdata[2:0];
        CFG_MAX_ITER: cfg_r.max_iterations <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  jet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  jet_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .cfg_i    (cfg_r),
    .in_data  (in_data),
    .cmd_i    (cmd),
    .status_o (status),
    .res_o    (res)
  );

  assign out_valid_nxt = cmd.finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result in its own register so the loop is free for the next request
  always_ff @(posedge clk) begin
    if (cmd.finish) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.escape_count <= cfg_r.max_iterations))
    else $error("escape count above iteration limit");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy still high while result is shown");

endmodule

### design/jet_ctrl.sv
module jet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  jet_pkg::status_t  status_i,
  output jet_pkg::cmd_t     cmd_o
);
  import jet_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (status_i.escaped || status_i.at_limit) state_nxt = ST_IDLE;
        else state_nxt = ST_MUL;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_MUL: cmd_o.mul = 1'b1;
      ST_EVAL: begin
        if (status_i.escaped || status_i.at_limit) cmd_o.finish = 1'b1;
        else cmd_o.step = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

### design/jet_dpath.sv
module jet_dpath #(
  parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  jet_pkg::cfg_t     cfg_i,
  input  jet_pkg::in_t      in_data,
  input  jet_pkg::cmd_t     cmd_i,
  output jet_pkg::status_t  status_o,
  output jet_pkg::out_t     res_o
);
  import jet_pkg::*;

  logic signed [31:0] re_r, im_r;
  logic signed [63:0] rr_r, ii_r, ri_r;
  logic [15:0]        count_r;

  logic [5:0]         rad_sq;
  logic [63:0]        limit;
  logic [63:0]        mag;
  logic signed [63:0] re_sum, im_sum;

  assign rad_sq = {3'b000, cfg_i.escape_radius} * {3'b000, cfg_i.escape_radius};
  assign limit  = 64'(rad_sq) << (2 * FRAC_BITS);
  assign mag    = $unsigned(rr_r) + $unsigned(ii_r);

  // floor division by arithmetic shift, then add c
  assign re_sum = ((rr_r - ii_r) >>> FRAC_BITS) + 64'(cfg_i.c_real);
  assign im_sum = (ri_r >>> (FRAC_BITS - 1)) + 64'(cfg_i.c_imag);

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      re_r    <= in_data.z_real;
      im_r    <= in_data.z_imag;
      count_r <= '0;
    end else if (cmd_i.step) begin
      re_r    <= sat32(re_sum);
      im_r    <= sat32(im_sum);
      count_r <= count_r + 16'd1;
    end
    if (cmd_i.mul) begin
      rr_r <= 64'(re_r) * 64'(re_r);
      ii_r <= 64'(im_r) * 64'(im_r);
      ri_r <= 64'(re_r) * 64'(im_r);
    end
  end

  assign status_o.escaped  = mag > limit;
  assign status_o.at_limit = count_r >= cfg_i.max_iterations;

  assign res_o.escape_count = count_r;
  assign res_o.shade_level  = shade_of(count_r);

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import jet_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PIXELS_PER_PHASE = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_C_REAL;
  logic [31:0] cfg_wdata = '0;

  julia_escape_time #(.FRAC_BITS(FRAC)) dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // one directed pixel; cfg_sel picks the register setting it runs under
  typedef struct packed {
    logic [2:0]         cfg_sel;
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;
    logic               typed;
    logic [15:0]        esc_count;
    logic [4:0]         shade;
  } pixel_row_t;

  typedef struct packed {
    logic typed;
    out_t result;
  } pending_t;

  // entry 0 is the reset setting and is never written
  cfg_t dir_cfgs [7] = '{
    '{32'sh00000000, 32'sh00000000, 3'd2, 16'd5000},
    '{32'sh00000000, 32'sh00000000, 3'd7, 16'd300},
    '{32'sh80000000, 32'sh7fffffff, 3'd7, 16'd65535},
    '{32'sh00000000, 32'sh00000000, 3'd0, 16'd10},
    '{32'sh04000000, 32'sh00000000, 3'd2, 16'd0},
    '{32'sh00000000, 32'sh00000000, 3'd2, 16'd65535},
    '{32'sh00000000, 32'sh00000000, 3'd1, 16'd1}
  };

  pixel_row_t dir_rows [24] = '{
    // reset setting: bounded origin, far corners, exactly on the radius
    '{3'd0, 32'sh00000000, 32'sh00000000, 1'b1, 16'd5000, 5'd12},
    '{3'd0, 32'sh80000000, 32'sh80000000, 1'b1, 16'd0,    5'd0},
    '{3'd0, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 16'd0,    5'd0},
    '{3'd0, 32'sh20000000, 32'sh00000000, 1'b1, 16'd1,    5'd1},
    '{3'd0, 32'sh20000001, 32'sh00000000, 1'b1, 16'd0,    5'd0},
    '{3'd0, 32'sh00000000, 32'she0000000, 1'b1, 16'd1,    5'd1},
    '{3'd0, 32'sh0ccccccd, 32'sh1999999a, 1'b0, 16'd0,    5'd0},
    // wide radius: updates that clamp both ways
    '{3'd1, 32'sh40000000, 32'sh40000000, 1'b0, 16'd0,    5'd0},
    '{3'd1, 32'shc0000000, 32'sh40000000, 1'b0, 16'd0,    5'd0},
    '{3'd1, 32'sh50000000, 32'sh00000000, 1'b0, 16'd0,    5'd0},
    '{3'd1, 32'sh00000000, 32'sh50000000, 1'b0, 16'd0,    5'd0},
    '{3'd1, 32'sh80000000, 32'sh00000000, 1'b1, 16'd0,    5'd0},
    // extreme c
    '{3'd2, 32'sh00000000, 32'sh00000000, 1'b1, 16'd1,    5'd1},
    '{3'd2, 32'sh7fffffff, 32'sh80000000, 1'b1, 16'd0,    5'd0},
    '{3'd2, 32'sh10000000, 32'sh00000000, 1'b0, 16'd0,    5'd0},
    // zero radius: only the origin stays
    '{3'd3, 32'sh00000000, 32'sh00000000, 1'b1, 16'd10,   5'd3},
    '{3'd3, 32'sh00000001, 32'sh00000000, 1'b1, 16'd0,    5'd0},
    '{3'd3, 32'sh00000000, 32'shffffffff, 1'b1, 16'd0,    5'd0},
    // zero limit
    '{3'd4, 32'sh00000000, 32'sh00000000, 1'b1, 16'd0,    5'd0},
    '{3'd4, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 16'd0,    5'd0},
    // largest limit, top shade
    '{3'd5, 32'sh00000000, 32'sh00000000, 1'b1, 16'd65535, 5'd16},
    // limit of one
    '{3'd6, 32'sh00000000, 32'sh00000000, 1'b1, 16'd1,    5'd1},
    '{3'd6, 32'sh10000000, 32'sh00000000, 1'b1, 16'd1,    5'd1},
    '{3'd6, 32'sh00000000, 32'sh10000000, 1'b1, 16'd1,    5'd1}
  };

  pending_t pending_pixels [$];
  out_t     expected_escapes [$];
  cfg_t     cfg_mirror;
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  logic     sender_gaps = 1'b1;

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic out_t predict_escape(input in_t px, input cfg_t c);
    longint          re;
    longint          im;
    longint          rr;
    longint          ii;
    longint          ri;
    longint unsigned mag;
    longint unsigned bound;
    int unsigned     iters;
    int unsigned     t;
    logic [4:0]      shade;
    out_t            res;
    re = px.z_real;
    im = px.z_imag;
    bound = longint'(c.escape_radius) * longint'(c.escape_radius);
    bound = bound << (2 * FRAC);
    iters = 0;
    forever begin
      rr = re * re;
      ii = im * im;
      ri = re * im;
      mag = rr + ii;
      if (mag > bound || iters >= c.max_iterations) begin
        break;
      end
      iters++;
      re = clamp_s32(((rr - ii) >>> FRAC) + longint'(c.c_real));
      im = clamp_s32((ri >>> (FRAC - 1)) + longint'(c.c_imag));
    end
    t = iters + 1;
    shade = '0;
    while (t > 1) begin
      t = t >> 1;
      shade++;
    end
    res.escape_count = iters[15:0];
    res.shade_level = shade;
    return res;
  endfunction

  function automatic logic signed [31:0] rand_fixed(input int unsigned span);
    return 32'(longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  task automatic send_pixel(input in_t px, input logic typed, input out_t res);
    pending_t req;
    while (sender_gaps && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
    req.typed = typed;
    req.result = res;
    pending_pixels.push_back(req);
    start <= 1'b1;
    in_data <= px;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_pixels.size() != 0 || expected_escapes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // junk in the unused upper bits must be dropped by the block
  task automatic apply_cfg(input cfg_t c);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_C_REAL;
    cfg_wdata <= c.c_real;
    @(posedge clk);
    cfg_addr <= CFG_C_IMAG;
    cfg_wdata <= c.c_imag;
    @(posedge clk);
    cfg_addr <= CFG_RADIUS;
    cfg_wdata <= {29'($urandom()), c.escape_radius};
    @(posedge clk);
    cfg_addr <= CFG_MAX_ITER;
    cfg_wdata <= {16'($urandom()), c.max_iterations};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    pending_t req;
    out_t     want;
    if (!rst_n) begin
      cfg_mirror = '{32'sh0, 32'sh0, 3'd2, 16'd5000};
      idle_cycles = 0;
    end else begin
      if (out_valid) begin
        if (expected_escapes.size() == 0) begin
          $error("result with no request waiting: escape_count %0d shade_level %0d",
                 out_data.escape_count, out_data.shade_level);
          mismatch_count++;
        end else begin
          want = expected_escapes.pop_front();
          if (out_data.escape_count !== want.escape_count) begin
            $error("escape_count: expected %0d, got %0d",
                   want.escape_count, out_data.escape_count);
            mismatch_count++;
          end
          if (out_data.shade_level !== want.shade_level) begin
            $error("shade_level: expected %0d, got %0d",
                   want.shade_level, out_data.shade_level);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_C_REAL:   cfg_mirror.c_real = cfg_wdata;
          CFG_C_IMAG:   cfg_mirror.c_imag = cfg_wdata;
          CFG_RADIUS:   cfg_mirror.escape_radius = cfg_wdata[2:0];
          CFG_MAX_ITER: cfg_mirror.max_iterations = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        req = pending_pixels.pop_front();
        expected_escapes.push_back(req.typed ? req.result
                                             : predict_escape(in_data, cfg_mirror));
      end
      if (out_valid || (start && !busy) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    pixel_row_t  row;
    in_t         px;
    out_t        res;
    cfg_t        c;
    logic [2:0]  cur_sel;
    int unsigned z_span;
    logic        zero_bias;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_sel = 3'd0;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.cfg_sel != cur_sel) begin
        drain_results();
        apply_cfg(dir_cfgs[row.cfg_sel]);
        cur_sel = row.cfg_sel;
      end
      px.z_real = row.z_real;
      px.z_imag = row.z_imag;
      res.escape_count = row.esc_count;
      res.shade_level = row.shade;
      send_pixel(px, row.typed, res);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      zero_bias = 1'b0;
      z_span = 32'h20000000;
      c.c_real = rand_fixed(32'h20000000);
      c.c_imag = rand_fixed(32'h20000000);
      case (ph)
        0: begin
          c.escape_radius = 3'd2;
          c.max_iterations = 16'($urandom_range(1, 64));
        end
        1: begin
          c.c_real = $urandom();
          c.c_imag = $urandom();
          c.escape_radius = 3'd7;
          c.max_iterations = 16'($urandom_range(100, 255));
          z_span = 32'h40000000;
        end
        2: begin
          // near a connected Julia set, so orbits run long
          c.c_real = -32'sd214748365 + rand_fixed(32'h00100000);
          c.c_imag = 32'sd41875931 + rand_fixed(32'h00100000);
          c.escape_radius = 3'd2;
          c.max_iterations = 16'd200;
        end
        3: begin
          c.escape_radius = 3'd0;
          c.max_iterations = 16'($urandom_range(1, 20));
          zero_bias = 1'b1;
        end
        4: begin
          c.escape_radius = 3'($urandom_range(0, 7));
          c.max_iterations = 16'd0;
          z_span = 32'h40000000;
        end
        default: begin
          // |c| past the radius keeps orbits short under the largest limit
          c.c_real = $urandom_range(32'h50000000, 32'h7fffffff);
          if ($urandom_range(0, 1) == 1) begin
            c.c_real = -c.c_real;
          end
          c.escape_radius = 3'd4;
          c.max_iterations = 16'd65535;
          z_span = 32'h40000000;
        end
      endcase
      apply_cfg(c);
      sender_gaps = (ph != 2);
      res = '0;
      repeat (PIXELS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 20) begin
          px.z_real = $urandom();
          px.z_imag = $urandom();
        end else if (zero_bias && $urandom_range(0, 2) == 0) begin
          px = '0;
        end else begin
          px.z_real = rand_fixed(z_span);
          px.z_imag = rand_fixed(z_span);
        end
        send_pixel(px, 1'b0, res);
      end
    end

    sender_gaps = 1'b1;
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_escapes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
